// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define CHK_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ppc_pkg.sv -----
// Package of the polygon plane clipper: defaults, register indexes and types.
package ppc_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int TOL_WIDTH       = 16;
   localparam int CSR_IDX_WIDTH   = 3;
   localparam int MAX_RESULTS     = 4;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_POINT_X   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_POINT_Y   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_POINT_Z   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NORMAL_X  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NORMAL_Y  = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NORMAL_Z  = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TOLERANCE = 3'd6;

   typedef enum logic [1:0] {
      VSEL_FIRST,
      VSEL_PREV,
      VSEL_CUR
   } vsel_type;

   typedef enum logic [1:0] {
      EDGE_FP,
      EDGE_PC,
      EDGE_CF
   } edge_type;

   typedef enum logic [1:0] {
      SIDE_CUR,
      SIDE_A,
      SIDE_B
   } side_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SIDE_MUL,
      ST_SIDE_ACC,
      ST_EDGE,
      ST_EMIT,
      ST_CHECK,
      ST_DIV,
      ST_LERP_MUL,
      ST_LERP_ADD,
      ST_FLUSH
   } state_type;

endpackage

// ----- hdl/polygon_plane_clipper_unit.sv -----
// Polygon plane clipper: one shared multiplier and a serial divider under a sequencer.
//
//  channel | dir | handshake            | word
//  req     | in  | req_tvalid/tready    | tdata x,y,z; tlast last vertex
//  rsp     | out | rsp_tvalid/tready    | tdata x,y,z; tuser vertex valid; tlast end
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
//  Each crossing adds two side products, a division at one divider bit per cycle and a lerp
//  of each coordinate, all on the single multiplier and the bit-serial divider.
//  Reset is synchronous; it clears the plane registers and the vertex count.
//  A stalled rsp holds the sequencer when a pending result or the end marker must be loaded.
module polygon_plane_clipper_unit #(
   parameter int COORD_WIDTH = ppc_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = ppc_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // vertex_x, vertex_y, vertex_z
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_x, out_y, out_z
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // vertex_valid
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [ppc_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [COORD_WIDTH-1:0]                csr_wdata
);

   localparam int CW    = COORD_WIDTH;
   localparam int MW    = CW + 1;
   localparam int PW    = 2 * MW;
   localparam int SW    = PW + 2;
   localparam int DW    = SW + 1;
   localparam int TDW   = ((3*CW+7)/8)*8;
   localparam int TW    = ppc_pkg::TOL_WIDTH;
   localparam int CNT_W = $clog2(FRAC_BITS);

   ppc_pkg::state_type state_ff, state_in;
   ppc_pkg::edge_type  edge_ff, nxt_edge;
   ppc_pkg::side_type  side_ret_ff;
   ppc_pkg::vsel_type  a_sel, b_sel, s_sel;

   logic signed [CW-1:0] pt_ff [3];
   logic signed [CW-1:0] nrm_ff [3];
   logic [TW-1:0]        tol_ff;

   logic [CW-1:0] first_ff [3];
   logic [CW-1:0] prev_ff [3];
   logic [CW-1:0] cur_ff [3];
   logic [CW-1:0] res_ff [3];
   logic [CW-1:0] pend_ff [3];
   logic [CW-1:0] rsp_ff [3];
   logic [CW-1:0] a_vec [3];
   logic [CW-1:0] b_vec [3];
   logic [CW-1:0] s_vec [3];
   logic          first_in_ff, prev_in_ff, cur_in_ff, last_ff;
   logic [1:0]    seen_ff;
   logic [1:0]    k_ff;
   logic [2:0]    n_ff;
   logic          from_a_ff, pend_v_ff;
   logic          rsp_valid_ff, rsp_user_ff, rsp_last_ff;
   logic          a_in, b_in;

   logic signed [SW-1:0] acc_ff, sa_ff, acc_sum, thresh;
   logic signed [PW-1:0] prod_ff, mul_p;
   logic signed [MW-1:0] mul_x, mul_y;
   logic signed [DW-1:0] den, num;
   logic [DW-1:0]        den_abs, num_abs, thr_d, ad_ff;
   logic [DW:0]          rem_ff, rem_sh;
   logic [FRAC_BITS-1:0] tq_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CW-1:0]        s_coord, a_coord, b_coord;

   logic rsp_free, rsp_load, rsp_ld_marker, rsp_ld_last, edge_adv, emit_go, flush_go;
   logic after_a_cross, rsp_from_pend;

   always_comb begin
      case (edge_ff)
         ppc_pkg::EDGE_FP: begin a_sel = ppc_pkg::VSEL_FIRST; b_sel = ppc_pkg::VSEL_PREV; end
         ppc_pkg::EDGE_PC: begin a_sel = ppc_pkg::VSEL_PREV;  b_sel = ppc_pkg::VSEL_CUR;  end
         ppc_pkg::EDGE_CF: begin a_sel = ppc_pkg::VSEL_CUR;   b_sel = ppc_pkg::VSEL_FIRST; end
         default:          begin a_sel = ppc_pkg::VSEL_FIRST; b_sel = ppc_pkg::VSEL_PREV; end
      endcase
      case (side_ret_ff)
         ppc_pkg::SIDE_CUR: s_sel = ppc_pkg::VSEL_CUR;
         ppc_pkg::SIDE_A:   s_sel = a_sel;
         ppc_pkg::SIDE_B:   s_sel = b_sel;
         default:           s_sel = ppc_pkg::VSEL_CUR;
      endcase
      for (int i = 0; i < 3; i++) begin
         case (a_sel)
            ppc_pkg::VSEL_PREV: a_vec[i] = prev_ff[i];
            ppc_pkg::VSEL_CUR:  a_vec[i] = cur_ff[i];
            default:            a_vec[i] = first_ff[i];
         endcase
         case (b_sel)
            ppc_pkg::VSEL_PREV: b_vec[i] = prev_ff[i];
            ppc_pkg::VSEL_CUR:  b_vec[i] = cur_ff[i];
            default:            b_vec[i] = first_ff[i];
         endcase
         case (s_sel)
            ppc_pkg::VSEL_PREV: s_vec[i] = prev_ff[i];
            ppc_pkg::VSEL_CUR:  s_vec[i] = cur_ff[i];
            default:            s_vec[i] = first_ff[i];
         endcase
      end
      case (a_sel)
         ppc_pkg::VSEL_PREV: a_in = prev_in_ff;
         ppc_pkg::VSEL_CUR:  a_in = cur_in_ff;
         default:            a_in = first_in_ff;
      endcase
      case (b_sel)
         ppc_pkg::VSEL_PREV: b_in = prev_in_ff;
         ppc_pkg::VSEL_CUR:  b_in = cur_in_ff;
         default:            b_in = first_in_ff;
      endcase

      s_coord = s_vec[k_ff];
      a_coord = a_vec[k_ff];
      b_coord = b_vec[k_ff];

      // shared multiplier
      if (state_ff == ppc_pkg::ST_LERP_MUL) begin
         mul_x = $signed({b_coord[CW-1], b_coord}) - $signed({a_coord[CW-1], a_coord});
         mul_y = $signed({{(MW-FRAC_BITS){1'b0}}, tq_ff});
      end else begin
         mul_x = $signed({s_coord[CW-1], s_coord}) - $signed({pt_ff[k_ff][CW-1], pt_ff[k_ff]});
         mul_y = $signed({nrm_ff[k_ff][CW-1], nrm_ff[k_ff]});
      end
      mul_p = mul_x * mul_y;

      acc_sum = acc_ff + $signed({{(SW-PW){prod_ff[PW-1]}}, prod_ff});
      thresh  = $signed({{(SW-TW-FRAC_BITS){1'b0}}, tol_ff, {FRAC_BITS{1'b0}}});
      thr_d   = {1'b0, thresh};
      den     = $signed({acc_ff[SW-1], acc_ff}) - $signed({sa_ff[SW-1], sa_ff});
      num     = -$signed({sa_ff[SW-1], sa_ff});
      den_abs = den[DW-1] ? DW'(-den) : DW'(den);
      num_abs = num[DW-1] ? DW'(-num) : DW'(num);
      rem_sh  = {rem_ff[DW-1:0], 1'b0};

      case (edge_ff)
         ppc_pkg::EDGE_FP: begin nxt_edge = ppc_pkg::EDGE_PC; end
         ppc_pkg::EDGE_PC: begin nxt_edge = last_ff ? ppc_pkg::EDGE_CF : ppc_pkg::EDGE_PC; end
         default:          begin nxt_edge = ppc_pkg::EDGE_CF; end
      endcase

      rsp_free      = !rsp_valid_ff || rsp_tready;
      after_a_cross = from_a_ff && (a_in != b_in);
      emit_go       = (n_ff >= 3'(ppc_pkg::MAX_RESULTS)) || !pend_v_ff || rsp_free;
      flush_go      = !(pend_v_ff || last_ff) || rsp_free;
      rsp_load      = 1'b0;
      rsp_ld_marker = 1'b0;
      rsp_ld_last   = 1'b0;
      rsp_from_pend = 1'b0;
      edge_adv      = 1'b0;
      state_in      = state_ff;

      case (state_ff)
         ppc_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ppc_pkg::ST_SIDE_MUL;
         end
         ppc_pkg::ST_SIDE_MUL: state_in = ppc_pkg::ST_SIDE_ACC;
         ppc_pkg::ST_SIDE_ACC: begin
            if (k_ff != 2'd2) begin
               state_in = ppc_pkg::ST_SIDE_MUL;
            end else begin
               case (side_ret_ff)
                  ppc_pkg::SIDE_CUR: state_in = (seen_ff < 2'd2) ? ppc_pkg::ST_FLUSH
                                                                 : ppc_pkg::ST_EDGE;
                  ppc_pkg::SIDE_A:   state_in = ppc_pkg::ST_SIDE_MUL;
                  default:           state_in = ppc_pkg::ST_CHECK;
               endcase
            end
         end
         ppc_pkg::ST_EDGE: begin
            if (a_in) begin
               state_in = ppc_pkg::ST_EMIT;
            end else if (b_in) begin
               state_in = ppc_pkg::ST_SIDE_MUL;
            end else begin
               edge_adv = 1'b1;
               state_in = (edge_ff == nxt_edge) ? ppc_pkg::ST_FLUSH : ppc_pkg::ST_EDGE;
            end
         end
         ppc_pkg::ST_EMIT: begin
            if (emit_go) begin
               if (n_ff < 3'(ppc_pkg::MAX_RESULTS) && pend_v_ff) begin
                  rsp_load      = 1'b1;
                  rsp_from_pend = 1'b1;
               end
               if (after_a_cross) begin
                  state_in = ppc_pkg::ST_SIDE_MUL;
               end else begin
                  edge_adv = 1'b1;
                  state_in = (edge_ff == nxt_edge) ? ppc_pkg::ST_FLUSH : ppc_pkg::ST_EDGE;
               end
            end
         end
         ppc_pkg::ST_CHECK: begin
            if (den == '0 || den_abs < thr_d || num == '0 || num[DW-1] != den[DW-1]
                || num_abs >= den_abs) begin
               state_in = ppc_pkg::ST_EMIT;
            end else begin
               state_in = ppc_pkg::ST_DIV;
            end
         end
         ppc_pkg::ST_DIV: begin
            if (cnt_ff == CNT_W'(FRAC_BITS-1)) state_in = ppc_pkg::ST_LERP_MUL;
         end
         ppc_pkg::ST_LERP_MUL: state_in = ppc_pkg::ST_LERP_ADD;
         ppc_pkg::ST_LERP_ADD: begin
            state_in = (k_ff == 2'd2) ? ppc_pkg::ST_EMIT : ppc_pkg::ST_LERP_MUL;
         end
         ppc_pkg::ST_FLUSH: begin
            if (flush_go) begin
               state_in = ppc_pkg::ST_IDLE;
               if (pend_v_ff || last_ff) begin
                  rsp_load      = 1'b1;
                  rsp_ld_last   = last_ff;
                  rsp_ld_marker = !pend_v_ff;
                  rsp_from_pend = pend_v_ff;
               end
            end
         end
         default: state_in = ppc_pkg::ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ppc_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppc_pkg::ST_IDLE;
         seen_ff      <= 2'd0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= '0;
         for (int i = 0; i < 3; i++) begin
            pt_ff[i]  <= '0;
            nrm_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_index)
               ppc_pkg::CSR_POINT_X:   pt_ff[0]  <= csr_wdata;
               ppc_pkg::CSR_POINT_Y:   pt_ff[1]  <= csr_wdata;
               ppc_pkg::CSR_POINT_Z:   pt_ff[2]  <= csr_wdata;
               ppc_pkg::CSR_NORMAL_X:  nrm_ff[0] <= csr_wdata;
               ppc_pkg::CSR_NORMAL_Y:  nrm_ff[1] <= csr_wdata;
               ppc_pkg::CSR_NORMAL_Z:  nrm_ff[2] <= csr_wdata;
               ppc_pkg::CSR_TOLERANCE: tol_ff    <= csr_wdata[TW-1:0];
               default: ;
            endcase
         end

         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         if (state_ff == ppc_pkg::ST_EMIT && emit_go
             && n_ff < 3'(ppc_pkg::MAX_RESULTS)) begin
            pend_v_ff <= 1'b1;
         end
         if (state_ff == ppc_pkg::ST_FLUSH && flush_go) begin
            pend_v_ff <= 1'b0;
            if (last_ff) seen_ff <= 2'd0;
            else if (seen_ff < 2'd2) seen_ff <= seen_ff + 2'd1;
            else seen_ff <= 2'd3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_user_ff <= !rsp_ld_marker;
         rsp_last_ff <= rsp_ld_last;
         for (int i = 0; i < 3; i++) rsp_ff[i] <= rsp_ld_marker ? '0 : pend_ff[i];
      end
      if (edge_adv) edge_ff <= nxt_edge;

      case (state_ff)
         ppc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cur_ff[0]   <= req_tdata[CW-1:0];
               cur_ff[1]   <= req_tdata[2*CW-1:CW];
               cur_ff[2]   <= req_tdata[3*CW-1:2*CW];
               last_ff     <= req_tlast;
               side_ret_ff <= ppc_pkg::SIDE_CUR;
               k_ff        <= 2'd0;
               n_ff        <= 3'd0;
            end
         end
         ppc_pkg::ST_SIDE_MUL: begin
            prod_ff <= mul_p;
            if (k_ff == 2'd0) acc_ff <= '0;
         end
         ppc_pkg::ST_SIDE_ACC: begin
            acc_ff <= acc_sum;
            if (k_ff != 2'd2) begin
               k_ff <= k_ff + 2'd1;
            end else begin
               k_ff <= 2'd0;
               case (side_ret_ff)
                  ppc_pkg::SIDE_CUR: begin
                     cur_in_ff <= (acc_sum <= thresh);
                     edge_ff   <= (seen_ff == 2'd2) ? ppc_pkg::EDGE_FP : ppc_pkg::EDGE_PC;
                  end
                  ppc_pkg::SIDE_A: begin
                     sa_ff       <= acc_sum;
                     side_ret_ff <= ppc_pkg::SIDE_B;
                  end
                  default: ;
               endcase
            end
         end
         ppc_pkg::ST_EDGE: begin
            from_a_ff <= 1'b1;
            k_ff      <= 2'd0;
            if (a_in) begin
               for (int i = 0; i < 3; i++) res_ff[i] <= a_vec[i];
            end else if (b_in) begin
               side_ret_ff <= ppc_pkg::SIDE_A;
            end
         end
         ppc_pkg::ST_EMIT: begin
            if (emit_go) begin
               k_ff <= 2'd0;
               if (n_ff < 3'(ppc_pkg::MAX_RESULTS)) begin
                  n_ff <= n_ff + 3'd1;
                  for (int i = 0; i < 3; i++) pend_ff[i] <= res_ff[i];
               end
               if (after_a_cross) side_ret_ff <= ppc_pkg::SIDE_A;
            end
         end
         ppc_pkg::ST_CHECK: begin
            from_a_ff <= 1'b0;
            ad_ff     <= den_abs;
            rem_ff    <= {1'b0, num_abs};
            tq_ff     <= '0;
            cnt_ff    <= '0;
            if (!(den == '0 || den_abs < thr_d || num == '0 || num[DW-1] != den[DW-1])
                && num_abs >= den_abs) begin
               for (int i = 0; i < 3; i++) res_ff[i] <= b_vec[i];
            end else begin
               for (int i = 0; i < 3; i++) res_ff[i] <= a_vec[i];
            end
         end
         ppc_pkg::ST_DIV: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            k_ff   <= 2'd0;
            if (rem_sh >= {1'b0, ad_ff}) begin
               rem_ff <= rem_sh - {1'b0, ad_ff};
               tq_ff  <= {tq_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               tq_ff  <= {tq_ff[FRAC_BITS-2:0], 1'b0};
            end
         end
         ppc_pkg::ST_LERP_MUL: prod_ff <= mul_p;
         ppc_pkg::ST_LERP_ADD: begin
            res_ff[k_ff] <= a_coord + prod_ff[FRAC_BITS+CW-1:FRAC_BITS];
            k_ff         <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
         end
         ppc_pkg::ST_FLUSH: begin
            if (flush_go) begin
               if (seen_ff == 2'd0) begin
                  for (int i = 0; i < 3; i++) first_ff[i] <= cur_ff[i];
                  first_in_ff <= cur_in_ff;
               end
               for (int i = 0; i < 3; i++) prev_ff[i] <= cur_ff[i];
               prev_in_ff <= cur_in_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = TDW'({rsp_ff[2], rsp_ff[1], rsp_ff[0]});

endmodule

// ----- hdl/ppc_checker.sv -----
// Port-level checker of the polygon plane clipper, bound to the top level.
`include "assert_macros.svh"

module ppc_checker #(
   parameter int COORD_WIDTH = ppc_pkg::COORD_WIDTH_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((3*COORD_WIDTH+7)/8)*8-1:0]  rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast
);

   `CHK_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp word dropped while stalled")
   `CHK_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast), "rsp word changed while stalled")
   `CHK_SAME(a_marker, rsp_tvalid && !rsp_tuser, rsp_tlast && rsp_tdata == '0, "end marker not last or not zero")
   `CHK_NEXT(a_busy, req_tvalid && req_tready, !req_tready, "ready right after an accepted vertex")

endmodule

bind polygon_plane_clipper_unit ppc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ppc_checker (.*);
